>>> rtl/scs_pkg.sv
// shared constants and helpers for the segment color smoother
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_PATH_MODE  = 3'd0;
   localparam logic [2:0] CSR_ALPHA      = 3'd1;
   localparam logic [2:0] CSR_SMOOTH     = 3'd2;
   localparam logic [2:0] CSR_SATURATION = 3'd3;
   localparam logic [2:0] CSR_SAT_MODE   = 3'd4;

   // path and saturation mode codes
   localparam logic PATH_MAP     = 1'b0;
   localparam logic PATH_REGION  = 1'b1;
   localparam logic SAT_LUMA     = 1'b0;
   localparam logic SAT_MIN_SUB  = 1'b1;

   // fixed point constants
   localparam logic [16:0] FULL_ONE  = 17'd65536;
   localparam logic [15:0] AVG_MAX   = 16'd65280;
   localparam logic [9:0]  SAT_ONE   = 10'd256;
   localparam logic [16:0] ALPHA_RST = 17'd32768;

   // rec.601 luma weights in q0.16, summing to one
   function automatic logic [16:0] luma_weight(input logic [1:0] ch);
      logic [16:0] w;
      case (ch)
         2'd0:    w = 17'd19595;
         2'd1:    w = 17'd38470;
         2'd2:    w = 17'd7471;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

   // 8.8 value to rounded display byte
   function automatic logic [7:0] to_byte(input logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, v} + 17'd128;
      return t[16] ? 8'hff : t[15:8];
   endfunction

endpackage
`default_nettype wire

>>> rtl/segment_color_smoother.sv
// segment color smoother top level: per segment rgb moving average with saturation
`timescale 1ns / 1ps
`default_nettype none
// Each request carries one sampled rgb byte triple for one led segment. The block keeps
// an 8.8 moving average per segment and channel in a small ram and returns one response
// with the rounded display color. The first sample of a segment after reset loads the
// average as is. Map path: avg moves toward the sample by alpha, then saturation is
// applied (neutral mode subtracts (sat-1)*min, luma mode scales around rec.601 luma).
// Region path: avg keeps weight smooth of its old value, no saturation. A segment index
// at or above SEGMENTS changes nothing and returns black. All multiplies go through one
// shared 18x18 multiplier under a sequencer, so one request is in flight at a time:
// out-of-range requests answer in the cycle after acceptance; in-range ones read the
// store, blend each channel (not for a first sample), then on the map path run the
// neutral or luma saturation steps. A new request is taken the cycle after the
// response is taken. Csr writes are always accepted and must only be issued while no
// request is in flight. No clearing pass is needed after reset.
module segment_color_smoother #(
   parameter int SEGMENTS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_segment,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [3:0]  rsp_out_segment,
   output logic      [7:0]  rsp_disp_red,
   output logic      [7:0]  rsp_disp_green,
   output logic      [7:0]  rsp_disp_blue,
   // configuration write port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int AW = SEGMENTS > 1 ? $clog2(SEGMENTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_BLEND_MUL, S_BLEND_ACC, S_SAT, S_NEU_MUL, S_NEU_APPLY,
      S_LUMA_MUL, S_LUMA_ACC, S_LUMA_DIV, S_GAIN_MUL, S_GAIN_ACC, S_DONE, S_OUT
   } state_type;

   // ---------------------------------------------------------------- config registers
   logic        path_mode_ff;
   logic [16:0] alpha_ff;
   logic [16:0] smooth_ff;
   logic [9:0]  saturation_ff;
   logic        sat_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         path_mode_ff  <= scs_pkg::PATH_MAP;
         alpha_ff      <= scs_pkg::ALPHA_RST;
         smooth_ff     <= scs_pkg::ALPHA_RST;
         saturation_ff <= scs_pkg::SAT_ONE;
         sat_mode_ff   <= scs_pkg::SAT_LUMA;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scs_pkg::CSR_PATH_MODE:  path_mode_ff  <= csr_data[0];
            scs_pkg::CSR_ALPHA:      alpha_ff      <= csr_data;
            scs_pkg::CSR_SMOOTH:     smooth_ff     <= csr_data;
            scs_pkg::CSR_SATURATION: saturation_ff <= csr_data[9:0];
            scs_pkg::CSR_SAT_MODE:   sat_mode_ff   <= csr_data[0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath registers
   state_type          state_ff;
   logic [AW-1:0]      addr_ff;
   logic [7:0]         smp_ff [3];   // captured sample bytes
   logic [15:0]        c_ff [3];     // working color, 8.8
   logic [1:0]         ch_ff;        // channel being worked on
   logic signed [35:0] prod_ff;      // registered multiplier output
   logic signed [35:0] acc_ff;       // luma accumulator
   logic [15:0]        luma_ff;
   logic [SEGMENTS-1:0] seen_ff;

   // ---------------------------------------------------------------- handshake
   logic req_fire;
   logic in_range;
   logic [AW-1:0] req_addr;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (32'(req_segment) < SEGMENTS);
   assign req_addr  = AW'(req_segment);

   // ---------------------------------------------------------------- average store
   logic        ram_we;
   logic [47:0] ram_rd_data;

   // averages are written back once blending is done
   assign ram_we = (state_ff == S_SAT);

   scs_ram #(
      .WIDTH (48),
      .DEPTH (SEGMENTS)
   ) u_avg_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data ({c_ff[0], c_ff[1], c_ff[2]}),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- blend weight
   logic [16:0] alpha_sat;
   logic [16:0] smooth_sat;
   logic [16:0] weight;

   // weights above one saturate to one
   assign alpha_sat  = (alpha_ff > scs_pkg::FULL_ONE) ? scs_pkg::FULL_ONE : alpha_ff;
   assign smooth_sat = (smooth_ff > scs_pkg::FULL_ONE) ? scs_pkg::FULL_ONE : smooth_ff;
   assign weight     = (path_mode_ff == scs_pkg::PATH_REGION) ?
                       (scs_pkg::FULL_ONE - smooth_sat) : alpha_sat;

   // ---------------------------------------------------------------- shared multiplier
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] mul_p;
   logic [15:0]        c_min;
   logic [15:0]        min01;

   assign min01 = (c_ff[0] < c_ff[1]) ? c_ff[0] : c_ff[1];
   assign c_min = (min01 < c_ff[2]) ? min01 : c_ff[2];

   always_comb begin
      case (state_ff)
         S_BLEND_MUL: begin
            // w * (sample - old), so new = old + that, rounded
            mul_a = $signed({1'b0, weight});
            mul_b = $signed({2'b00, smp_ff[ch_ff], 8'h00}) - $signed({2'b00, c_ff[ch_ff]});
         end
         S_NEU_MUL: begin
            mul_a = $signed({8'h00, saturation_ff - scs_pkg::SAT_ONE});
            mul_b = $signed({2'b00, c_min});
         end
         S_LUMA_MUL: begin
            mul_a = $signed({1'b0, scs_pkg::luma_weight(ch_ff)});
            mul_b = $signed({2'b00, c_ff[ch_ff]});
         end
         S_GAIN_MUL: begin
            mul_a = $signed({8'h00, saturation_ff});
            mul_b = $signed({2'b00, c_ff[ch_ff]}) - $signed({2'b00, luma_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // ---------------------------------------------------------------- step results
   logic signed [35:0] blend_sum;
   logic signed [35:0] luma_sum;
   logic signed [35:0] neu_sub;
   logic signed [35:0] gain_abs;
   logic signed [35:0] gain_rnd;
   logic signed [35:0] gain_q;
   logic signed [35:0] gain_v;
   logic [15:0]        gain_in;
   logic [15:0]        neu_in [3];

   assign blend_sum = $signed({4'h0, c_ff[ch_ff], 16'h0000}) + 36'sd32768 + prod_ff;
   assign luma_sum  = acc_ff + 36'sd32768;

   // neutral: subtract the rounded k*min, floored at zero
   assign neu_sub = (prod_ff + 36'sd128) >>> 8;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if ($signed({20'h00000, c_ff[i]}) < neu_sub) begin
            neu_in[i] = '0;
         end else begin
            neu_in[i] = c_ff[i] - neu_sub[15:0];
         end
      end
   end

   // luma gain: round half away from zero, then clamp to 0 .. AVG_MAX (255.0 in 8.8)
   assign gain_abs = prod_ff[35] ? -prod_ff : prod_ff;
   assign gain_rnd = (gain_abs + 36'sd128) >>> 8;
   assign gain_q   = prod_ff[35] ? -gain_rnd : gain_rnd;
   assign gain_v   = $signed({20'h00000, luma_ff}) + gain_q;
   always_comb begin
      if (gain_v < 36'sd0) begin
         gain_in = '0;
      end else if (gain_v > $signed({20'h00000, scs_pkg::AVG_MAX})) begin
         gain_in = scs_pkg::AVG_MAX;
      end else begin
         gain_in = gain_v[15:0];
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         seen_ff   <= '0;
         ch_ff     <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  addr_ff         <= req_addr;
                  smp_ff[0]       <= req_red;
                  smp_ff[1]       <= req_green;
                  smp_ff[2]       <= req_blue;
                  rsp_out_segment <= req_segment;
                  if (in_range) begin
                     state_ff <= S_READ;
                  end else begin
                     // unknown segment: black, no state change
                     rsp_disp_red   <= '0;
                     rsp_disp_green <= '0;
                     rsp_disp_blue  <= '0;
                     rsp_valid      <= 1'b1;
                     state_ff       <= S_OUT;
                  end
               end
            end
            S_READ: begin
               ch_ff <= '0;
               if (seen_ff[addr_ff]) begin
                  c_ff[0]  <= ram_rd_data[47:32];
                  c_ff[1]  <= ram_rd_data[31:16];
                  c_ff[2]  <= ram_rd_data[15:0];
                  state_ff <= S_BLEND_MUL;
               end else begin
                  // first sample loads the average
                  c_ff[0]  <= {smp_ff[0], 8'h00};
                  c_ff[1]  <= {smp_ff[1], 8'h00};
                  c_ff[2]  <= {smp_ff[2], 8'h00};
                  state_ff <= S_SAT;
               end
            end
            S_BLEND_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_BLEND_ACC;
            end
            S_BLEND_ACC: begin
               c_ff[ch_ff] <= blend_sum[31:16];
               if (ch_ff == 2'd2) begin
                  state_ff <= S_SAT;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_BLEND_MUL;
               end
            end
            S_SAT: begin
               seen_ff[addr_ff] <= 1'b1;
               ch_ff            <= '0;
               acc_ff           <= '0;
               if (path_mode_ff == scs_pkg::PATH_REGION) begin
                  state_ff <= S_DONE;
               end else if (sat_mode_ff == scs_pkg::SAT_MIN_SUB) begin
                  state_ff <= (saturation_ff > scs_pkg::SAT_ONE) ? S_NEU_MUL : S_DONE;
               end else begin
                  state_ff <= (saturation_ff != scs_pkg::SAT_ONE) ? S_LUMA_MUL : S_DONE;
               end
            end
            S_NEU_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_NEU_APPLY;
            end
            S_NEU_APPLY: begin
               c_ff[0]  <= neu_in[0];
               c_ff[1]  <= neu_in[1];
               c_ff[2]  <= neu_in[2];
               state_ff <= S_DONE;
            end
            S_LUMA_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_LUMA_ACC;
            end
            S_LUMA_ACC: begin
               acc_ff <= acc_ff + prod_ff;
               if (ch_ff == 2'd2) begin
                  state_ff <= S_LUMA_DIV;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_LUMA_MUL;
               end
            end
            S_LUMA_DIV: begin
               luma_ff  <= luma_sum[31:16];
               ch_ff    <= '0;
               state_ff <= S_GAIN_MUL;
            end
            S_GAIN_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= S_GAIN_ACC;
            end
            S_GAIN_ACC: begin
               c_ff[ch_ff] <= gain_in;
               if (ch_ff == 2'd2) begin
                  state_ff <= S_DONE;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= S_GAIN_MUL;
               end
            end
            S_DONE: begin
               rsp_disp_red   <= scs_pkg::to_byte(c_ff[0]);
               rsp_disp_green <= scs_pkg::to_byte(c_ff[1]);
               rsp_disp_blue  <= scs_pkg::to_byte(c_ff[2]);
               rsp_valid      <= 1'b1;
               state_ff       <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- assertions
   a_ready_xor_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_range_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && in_range |=> state_ff == S_READ)
      else $error("in-range request did not start the store read");

   a_range_black: assert property (@(posedge clock) disable iff (reset)
      req_fire && !in_range |=> rsp_valid && rsp_disp_red == 8'h00 &&
      rsp_disp_green == 8'h00 && rsp_disp_blue == 8'h00)
      else $error("out-of-range request not answered with black");

   a_ram_addr: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> 32'(addr_ff) < SEGMENTS)
      else $error("average store written at an unknown segment");

   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("sequencer did not return to idle after response");

endmodule
`default_nettype wire

>>> rtl/scs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module scs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 10
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire
